// ===== sv/tfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared types, codes and the microcode table of the trimmed field splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package tfs_pkg;

  // reset value of the separator register (comma)
  localparam logic [7:0] SEP_RESET = 8'd44;

  localparam logic [7:0] CHR_SPACE = 8'd32;
  localparam logic [7:0] CHR_TAB   = 8'd9;
  localparam logic [7:0] CHR_CR    = 8'd13;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       field_last;
    logic       overflowed;
  } out_item_t;

  typedef enum logic [2:0] {
    MODE_LEAD  = 3'b001,
    MODE_DATA  = 3'b010,
    MODE_ABORT = 3'b100
  } mode_t;

  // microcode step addresses
  typedef logic [1:0] step_t;
  localparam step_t STEP_FETCH = 2'd0;
  localparam step_t STEP_OVF   = 2'd1;
  localparam step_t STEP_RD    = 2'd2;
  localparam step_t STEP_LD    = 2'd3;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_RAM  = 2'd1,
    SRC_OVF  = 2'd2
  } out_src_t;

  typedef enum logic [1:0] {
    JMP_DISPATCH = 2'd0,
    JMP_GOTO     = 2'd1,
    JMP_LOOP     = 2'd2
  } jump_t;

  typedef struct packed {
    logic     take_in;
    out_src_t src;
    jump_t    jmp;
    step_t    target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t cw;
    unique case (step)
      STEP_FETCH: cw = '{take_in: 1'b1, src: SRC_NONE, jmp: JMP_DISPATCH, target: STEP_FETCH};
      STEP_OVF:   cw = '{take_in: 1'b0, src: SRC_OVF,  jmp: JMP_GOTO,     target: STEP_FETCH};
      STEP_RD:    cw = '{take_in: 1'b0, src: SRC_NONE, jmp: JMP_GOTO,     target: STEP_LD};
      STEP_LD:    cw = '{take_in: 1'b0, src: SRC_RAM,  jmp: JMP_LOOP,     target: STEP_RD};
      default:    cw = '{take_in: 1'b1, src: SRC_NONE, jmp: JMP_DISPATCH, target: STEP_FETCH};
    endcase
    return cw;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));
  endfunction

endpackage

`default_nettype wire

// ===== sv/trimmed_field_splitter_top.sv =====
// ----------------------------------------------------------------------------
// trimmed_field_splitter_top
// Splits a byte string into separator-delimited, whitespace-trimmed fields.
// ----------------------------------------------------------------------------
// Input words carry one string byte and a string-end flag; output words carry
// one byte of a trimmed field with a last-of-field mark, or a single overflow
// word when a field outgrows the FIELD_CAP-1 byte buffer (the rest of that
// string is then dropped). The cfg port writes the separator byte.
//
// A byte that closes no field is taken with the sequencer in its fetch step.
// A byte that closes a field holds in_ready low while the field buffer RAM
// is read back (a read step and an output load step per kept byte, from its
// registered read port); each byte enters the output register in the load
// step after its read step. An overflow word is loaded in the overflow step.
// When the receiver stalls, the sequencer waits on the output register and
// input stays blocked until the last word of a field is loaded into it; that
// word may still wait there while the next input is taken.
//
// Reset (synchronous, active low) sets the separator to ',' and returns to
// leading-whitespace mode; the field buffer is not cleared, only bytes of
// the current field are ever read back.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_field_splitter_top #(
  parameter int FIELD_CAP = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tfs_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tfs_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata
);

  import tfs_pkg::*;

  localparam int DEPTH = FIELD_CAP - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(FIELD_CAP);

  logic [7:0]    sep_r;
  mode_t         mode_r, mode_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [AW-1:0] em_last_r, em_last_nxt;
  logic [AW-1:0] emit_idx_r, emit_idx_nxt;
  step_t         step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  ctrl_word_t    cw;
  logic          in_fire;
  logic          slot_free;
  logic          stall;
  logic          at_last;
  step_t         disp_target;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_rdata;
  logic          c_ws;
  logic          c_sep;
  logic [AW-1:0] solid_pos;

  assign cw        = ucode_rom(step_r);
  assign in_ready  = cw.take_in;
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign stall     = (cw.src != SRC_NONE) && !slot_free;
  assign at_last   = (emit_idx_r == em_last_r);
  assign c_ws      = is_ws(in_data.in_byte);
  assign c_sep     = (in_data.in_byte == sep_r);
  assign solid_pos = c_ws ? last_r : count_r[AW-1:0];

  // parse decision for the byte on the input, applied when it is taken
  always_comb begin
    mode_nxt    = mode_r;
    count_nxt   = count_r;
    last_nxt    = last_r;
    em_last_nxt = em_last_r;
    disp_target = STEP_FETCH;
    ram_we      = 1'b0;
    ram_waddr   = count_r[AW-1:0];
    unique case (mode_r)
      MODE_ABORT: begin
        if (in_data.string_end) begin
          mode_nxt = MODE_LEAD;
        end
      end
      MODE_DATA: begin
        if (c_sep) begin
          em_last_nxt = last_r;
          count_nxt   = '0;
          last_nxt    = '0;
          mode_nxt    = MODE_LEAD;
          disp_target = STEP_RD;
        end else if (count_r == CW'(DEPTH)) begin
          count_nxt   = '0;
          last_nxt    = '0;
          mode_nxt    = in_data.string_end ? MODE_LEAD : MODE_ABORT;
          disp_target = STEP_OVF;
        end else begin
          ram_we    = 1'b1;
          last_nxt  = solid_pos;
          count_nxt = count_r + CW'(1);
          if (in_data.string_end) begin
            em_last_nxt = solid_pos;
            count_nxt   = '0;
            last_nxt    = '0;
            mode_nxt    = MODE_LEAD;
            disp_target = STEP_RD;
          end
        end
      end
      default: begin
        // leading whitespace, also any stray mode code
        mode_nxt = MODE_LEAD;
        if (!(c_ws || c_sep)) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          count_nxt = CW'(1);
          last_nxt  = '0;
          mode_nxt  = MODE_DATA;
          if (in_data.string_end) begin
            em_last_nxt = '0;
            count_nxt   = '0;
            mode_nxt    = MODE_LEAD;
            disp_target = STEP_RD;
          end
        end
      end
    endcase
  end

  // sequencer: next step and output register loads
  always_comb begin
    step_nxt      = step_r;
    emit_idx_nxt  = emit_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (cw.jmp)
      JMP_DISPATCH: begin
        if (in_fire) begin
          step_nxt     = disp_target;
          emit_idx_nxt = '0;
        end
      end
      JMP_GOTO: begin
        if (!stall) begin
          step_nxt = cw.target;
        end
      end
      JMP_LOOP: begin
        if (!stall) begin
          if (at_last) begin
            step_nxt = STEP_FETCH;
          end else begin
            step_nxt     = cw.target;
            emit_idx_nxt = emit_idx_r + AW'(1);
          end
        end
      end
      default: begin
        step_nxt = STEP_FETCH;
      end
    endcase
    if (!stall) begin
      case (cw.src)
        SRC_RAM: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_byte: ram_rdata, field_last: at_last, overflowed: 1'b0};
        end
        SRC_OVF: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_byte: 8'd0, field_last: 1'b0, overflowed: 1'b1};
        end
        default: begin
        end
      endcase
    end
  end

  tfs_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_field_ram (
    .clk   (clk),
    .we    (in_fire && ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.in_byte),
    .raddr (emit_idx_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r       <= SEP_RESET;
      mode_r      <= MODE_LEAD;
      count_r     <= '0;
      last_r      <= '0;
      step_r      <= STEP_FETCH;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        sep_r <= cfg_wdata;
      end
      if (in_fire) begin
        mode_r  <= mode_nxt;
        count_r <= count_nxt;
        last_r  <= last_nxt;
      end
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      em_last_r <= em_last_nxt;
    end
    emit_idx_r <= emit_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_ovf_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflowed) |-> (out_data.out_byte == 8'd0 && !out_data.field_last))
    else $error("overflow word carries byte data");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("field count beyond buffer depth");

  a_abort_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ABORT) |-> (count_r == '0))
    else $error("aborted string still holds field bytes");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_LD || step_r == STEP_RD) |-> (emit_idx_r <= em_last_r && !in_ready))
    else $error("read-back ran past the trimmed field end");

endmodule

`default_nettype wire

// ===== sv/tfs_ram.sv =====
// ----------------------------------------------------------------------------
// tfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
